/* rtl/double_ended_queue_with_search_defines.svh */
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DQS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DQS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dqs_pkg.sv */
// Types and constants of the double-ended queue with search.
`timescale 1ns / 1ps
`default_nettype none

package dqs_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_WIDTH      = 3;
   localparam int VALUE_WIDTH    = 32;
   localparam int INDEX_WIDTH    = 7;
   localparam int STATUS_WIDTH   = 3;
   localparam int POSITION_WIDTH = 6;
   localparam int COUNT_WIDTH    = 7;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_READ       = 3'd4,
      CMD_SEARCH     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STS_OK        = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_FULL      = 3'd2,
      STS_RANGE     = 3'd3,
      STS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE   = 4'b0001,
      FSM_FETCH  = 4'b0010,
      FSM_SEARCH = 4'b0100,
      FSM_REPLY  = 4'b1000
   } fsm_type;

   // Data returned by a pop on an empty queue.
   localparam logic [VALUE_WIDTH-1:0] EMPTY_POP_DATA = '1;

endpackage

`default_nettype wire

/* rtl/dqs_ram.sv */
// Simple dual-port entry store, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dqs_ram #(
   parameter int DEPTH      = dqs_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEFAULT,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/double_ended_queue_with_search.sv */
// Double-ended queue with indexed read and linear search, top level.
//
// Usage:
//   Request channel (req_*): cmd, value, index; taken when req_valid is high
//   and req_stall low. One request is in flight at a time; req_stall is high
//   from the accepting edge until the response is handed to the output reg.
//   Response channel (rsp_*): status, data, position, count; one response per
//   request, taken when rsp_valid is high and rsp_stall low.
//   Every command but search passes from IDLE to FETCH or REPLY and loads
//   the response register from there once it is free; pops and indexed
//   reads issue the synchronous memory read at the accepting edge, so the
//   data is ready in FETCH. Search: one memory read per walked entry, up
//   to the fill count, then REPLY; the single memory read port makes the
//   walk go one entry at a time.
//   Reset (synchronous, active high) empties the queue at once: head and fill
//   count clear; stored entries are left as they are and never read unwritten.
//   A stalled response stays in the output register; the block then holds
//   its finished result and takes no new request until the register frees.
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_with_search_defines.svh"

module double_ended_queue_with_search #(
   parameter int DEPTH      = dqs_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,

   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic        [dqs_pkg::CMD_WIDTH-1:0]        req_cmd,
   input  wire logic signed [dqs_pkg::VALUE_WIDTH-1:0]      req_value,
   input  wire logic signed [dqs_pkg::INDEX_WIDTH-1:0]      req_index,

   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic             [dqs_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic signed      [dqs_pkg::VALUE_WIDTH-1:0]      rsp_data,
   output logic             [dqs_pkg::POSITION_WIDTH-1:0]   rsp_position,
   output logic             [dqs_pkg::COUNT_WIDTH-1:0]      rsp_count
);

   // slot/position width, fill count width (holds DEPTH itself)
   localparam int PW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   // width for comparing an index magnitude against the fill count
   localparam int KW = (FW > dqs_pkg::INDEX_WIDTH) ? FW : dqs_pkg::INDEX_WIDTH;
   localparam logic [PW:0] DEPTH_EXT = (PW + 1)'(DEPTH);
   localparam int IW = dqs_pkg::INDEX_WIDTH;
   localparam int VW = dqs_pkg::VALUE_WIDTH;

   // ring slot of a position counted from the head; sum stays below 2*DEPTH
   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] head,
                                              input logic [PW-1:0] pos);
      logic [PW:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[PW-1:0];
   endfunction

   // ---------------------------------------------------------------- state
   dqs_pkg::fsm_type    fsm_ff, fsm_in;
   logic [PW-1:0]       head_ff, head_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [PW-1:0]       srch_pos_ff, srch_pos_in;

   // finished result waiting for the output register
   dqs_pkg::status_type res_status_ff, res_status_in;
   logic [VW-1:0]       res_data_ff, res_data_in;
   logic [PW-1:0]       res_pos_ff, res_pos_in;

   // output register
   logic                                   rsp_valid_ff, rsp_valid_in;
   dqs_pkg::status_type                    rsp_status_ff, rsp_status_in;
   logic [VW-1:0]                          rsp_data_ff, rsp_data_in;
   logic [dqs_pkg::POSITION_WIDTH-1:0]     rsp_position_ff, rsp_position_in;
   logic [dqs_pkg::COUNT_WIDTH-1:0]        rsp_count_ff, rsp_count_in;

   // memory port
   logic                  ram_we;
   logic [PW-1:0]         ram_waddr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic                  ram_re;
   logic [PW-1:0]         ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   dqs_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_WIDTH (PW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------- request decoding
   dqs_pkg::cmd_type cmd;
   logic             req_accept;
   logic             rsp_free;
   logic             is_empty;
   logic             is_full;
   logic [DATA_WIDTH-1:0] value_st;
   logic             idx_neg;
   logic [IW-1:0]    idx_bits;
   logic [IW-1:0]    idx_mag;
   logic [KW-1:0]    mag_ext;
   logic [KW-1:0]    fill_ext;
   logic             idx_ok;
   logic [PW-1:0]    read_pos;
   logic [FW-1:0]    fill_dec;
   logic [PW-1:0]    back_pos;
   logic [PW-1:0]    head_dec;
   logic [PW-1:0]    head_inc;
   logic [PW-1:0]    srch_next;
   logic             srch_hit;
   logic             srch_last;

   assign cmd        = dqs_pkg::cmd_type'(req_cmd);
   assign req_stall  = (fsm_ff != dqs_pkg::FSM_IDLE);
   assign req_accept = req_valid && !req_stall;
   // output register can take a response this cycle
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign is_empty = (fill_ff == '0);
   assign is_full  = (fill_ff == FW'(DEPTH));

   // value brought to the stored width, sign-extended when wider
   assign value_st = DATA_WIDTH'(req_value);

   // negative index -k reads k places before the tail
   assign idx_neg  = req_index[IW-1];
   assign idx_bits = req_index;
   assign idx_mag  = idx_neg ? (IW'(0) - idx_bits) : idx_bits;
   assign mag_ext  = KW'(idx_mag);
   assign fill_ext = KW'(fill_ff);
   assign idx_ok   = (mag_ext < fill_ext);
   assign read_pos = idx_neg ? PW'(fill_ext - KW'(1) - mag_ext) : PW'(idx_mag);

   assign fill_dec = fill_ff - FW'(1);
   assign back_pos = PW'(fill_dec);
   assign head_dec = (head_ff == '0) ? PW'(DEPTH - 1) : (head_ff - PW'(1));
   assign head_inc = slot_of(head_ff, PW'(1));

   // search walk: memory data belongs to srch_pos_ff
   assign srch_next = srch_pos_ff + PW'(1);
   assign srch_hit  = (ram_rdata == key_ff);
   assign srch_last = ((FW'(srch_pos_ff) + FW'(1)) == fill_ff);

   assign ram_wdata = value_st;

   // ------------------------------------------------------------- control
   always_comb begin
      fsm_in        = fsm_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      key_in        = key_ff;
      srch_pos_in   = srch_pos_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_pos_in    = res_pos_ff;

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;

      ram_we    = 1'b0;
      ram_waddr = head_ff;
      ram_re    = 1'b0;
      ram_raddr = head_ff;

      unique case (fsm_ff)
         dqs_pkg::FSM_IDLE: begin
            if (req_accept) begin
               res_status_in = dqs_pkg::STS_OK;
               res_data_in   = '0;
               res_pos_in    = '0;
               fsm_in        = dqs_pkg::FSM_REPLY;
               unique case (cmd)
                  dqs_pkg::CMD_PUSH_BACK: begin
                     if (is_full) begin
                        res_status_in = dqs_pkg::STS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_of(head_ff, PW'(fill_ff));
                        fill_in   = fill_ff + FW'(1);
                     end
                  end
                  dqs_pkg::CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        res_status_in = dqs_pkg::STS_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                        head_in   = head_dec;
                        fill_in   = fill_ff + FW'(1);
                     end
                  end
                  dqs_pkg::CMD_POP_BACK: begin
                     if (is_empty) begin
                        res_status_in = dqs_pkg::STS_EMPTY;
                        res_data_in   = dqs_pkg::EMPTY_POP_DATA;
                     end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot_of(head_ff, back_pos);
                        fill_in    = fill_dec;
                        res_pos_in = back_pos;
                        fsm_in     = dqs_pkg::FSM_FETCH;
                     end
                  end
                  dqs_pkg::CMD_POP_FRONT: begin
                     if (is_empty) begin
                        res_status_in = dqs_pkg::STS_EMPTY;
                        res_data_in   = dqs_pkg::EMPTY_POP_DATA;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        head_in   = head_inc;
                        fill_in   = fill_dec;
                        fsm_in    = dqs_pkg::FSM_FETCH;
                     end
                  end
                  dqs_pkg::CMD_READ: begin
                     if (is_empty) begin
                        res_status_in = dqs_pkg::STS_EMPTY;
                     end else if (!idx_ok) begin
                        res_status_in = dqs_pkg::STS_RANGE;
                     end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot_of(head_ff, read_pos);
                        res_pos_in = read_pos;
                        fsm_in     = dqs_pkg::FSM_FETCH;
                     end
                  end
                  dqs_pkg::CMD_SEARCH: begin
                     if (is_empty) begin
                        res_status_in = dqs_pkg::STS_EMPTY;
                     end else begin
                        ram_re      = 1'b1;
                        ram_raddr   = head_ff;
                        key_in      = value_st;
                        srch_pos_in = '0;
                        fsm_in      = dqs_pkg::FSM_SEARCH;
                     end
                  end
                  default: begin
                     // unused codes: no change, plain ok
                     res_status_in = dqs_pkg::STS_OK;
                  end
               endcase
            end
         end

         dqs_pkg::FSM_FETCH: begin
            // read data holds until the output register frees
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_data_in     = VW'(ram_rdata);
               rsp_position_in = dqs_pkg::POSITION_WIDTH'(res_pos_ff);
               rsp_count_in    = dqs_pkg::COUNT_WIDTH'(fill_ff);
               fsm_in          = dqs_pkg::FSM_IDLE;
            end
         end

         dqs_pkg::FSM_SEARCH: begin
            if (srch_hit) begin
               res_status_in = dqs_pkg::STS_OK;
               res_data_in   = VW'(ram_rdata);
               res_pos_in    = srch_pos_ff;
               fsm_in        = dqs_pkg::FSM_REPLY;
            end else if (srch_last) begin
               res_status_in = dqs_pkg::STS_NOT_FOUND;
               res_data_in   = '0;
               res_pos_in    = '0;
               fsm_in        = dqs_pkg::FSM_REPLY;
            end else begin
               ram_re      = 1'b1;
               ram_raddr   = slot_of(head_ff, srch_next);
               srch_pos_in = srch_next;
            end
         end

         dqs_pkg::FSM_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_data_in     = res_data_ff;
               rsp_position_in = dqs_pkg::POSITION_WIDTH'(res_pos_ff);
               rsp_count_in    = dqs_pkg::COUNT_WIDTH'(fill_ff);
               fsm_in          = dqs_pkg::FSM_IDLE;
            end
         end

         default: begin
            fsm_in = dqs_pkg::FSM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= dqs_pkg::FSM_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      srch_pos_ff     <= srch_pos_in;
      res_status_ff   <= res_status_in;
      res_data_ff     <= res_data_in;
      res_pos_ff      <= res_pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

   // ---------------------------------------------------------- assertions
   `DQS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_ff <= FW'(DEPTH), "fill count above depth")
   `DQS_ASSERT_IMPL(a_head_bound, 1'b1, head_ff <= PW'(DEPTH - 1), "head slot out of ring")
   `DQS_ASSERT_IMPL(a_search_pos, fsm_ff == dqs_pkg::FSM_SEARCH, FW'(srch_pos_ff) < fill_ff, "search walked past tail")
   `DQS_ASSERT_NEXT(a_push_grows, req_accept && !is_full && ((cmd == dqs_pkg::CMD_PUSH_BACK) || (cmd == dqs_pkg::CMD_PUSH_FRONT)), fill_ff == $past(fill_ff) + FW'(1), "push did not grow queue")
   `DQS_ASSERT_NEXT(a_pop_shrinks, req_accept && !is_empty && ((cmd == dqs_pkg::CMD_POP_BACK) || (cmd == dqs_pkg::CMD_POP_FRONT)), fill_ff == $past(fill_ff) - FW'(1), "pop did not shrink queue")

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the double-ended queue with indexed read and search.
`timescale 1ns / 1ps

module tb;

   localparam int QUEUE_DEPTH = dqs_pkg::DEPTH_DEFAULT;
   localparam int IDX_W = dqs_pkg::INDEX_WIDTH;
   localparam int POS_W = dqs_pkg::POSITION_WIDTH;
   localparam int CNT_W = dqs_pkg::COUNT_WIDTH;
   // Command codes with no operation behind them.
   localparam logic [dqs_pkg::CMD_WIDTH-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [dqs_pkg::CMD_WIDTH-1:0] CMD_UNUSED_HI = 3'd7;
   // Most negative index, one past the usual range.
   localparam logic signed [IDX_W-1:0] INDEX_MIN = {1'b1, {(IDX_W-1){1'b0}}};
   // Total requests, directed ones included; the run stops offering at this count.
   localparam int REQUEST_TOTAL = 750;
   // Cycles with no request and no response taken before the run is called hung.
   // The longest quiet stretch of a correct run is the receiver hold-off plus
   // one full-queue search, so this leaves a wide margin.
   localparam int HANG_LIMIT = 2000;
   // Drain time after the last response: longer than a full-queue search.
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      dqs_pkg::status_type      status;
      logic signed [31:0]       data;
      logic [POS_W-1:0]         position;
      logic [CNT_W-1:0]         count;
   } dq_result_type;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_kind_type;

   // Mirror of the deque plus the list of responses still owed by the block.
   class deque_checker_type;
      logic signed [31:0] store[$];
      dq_result_type      owed[$];
      int                 error_count;

      function new();
         error_count = 0;
      endfunction

      function int fill_level();
         return store.size();
      endfunction

      function logic signed [31:0] entry_at(int pos);
         return store[pos];
      endfunction

      function int outstanding();
         return owed.size();
      endfunction

      // Apply one accepted request to the mirror and queue the response it owes.
      function void note_request(dqs_pkg::cmd_type cmd, logic signed [31:0] value,
                                 logic signed [IDX_W-1:0] index);
         dq_result_type r;
         int k;
         int p;
         r.status = dqs_pkg::STS_OK;
         r.data = '0;
         r.position = '0;
         case (cmd)
            dqs_pkg::CMD_PUSH_BACK: begin
               if (store.size() >= QUEUE_DEPTH) r.status = dqs_pkg::STS_FULL;
               else store.push_back(value);
            end
            dqs_pkg::CMD_PUSH_FRONT: begin
               if (store.size() >= QUEUE_DEPTH) r.status = dqs_pkg::STS_FULL;
               else store.push_front(value);
            end
            dqs_pkg::CMD_POP_BACK: begin
               if (store.size() == 0) begin
                  r.status = dqs_pkg::STS_EMPTY;
                  r.data = dqs_pkg::EMPTY_POP_DATA;
               end else begin
                  // position is the tail slot, counted before the pop
                  r.position = POS_W'(store.size() - 1);
                  r.data = store.pop_back();
               end
            end
            dqs_pkg::CMD_POP_FRONT: begin
               if (store.size() == 0) begin
                  r.status = dqs_pkg::STS_EMPTY;
                  r.data = dqs_pkg::EMPTY_POP_DATA;
               end else begin
                  r.data = store.pop_front();
               end
            end
            dqs_pkg::CMD_READ: begin
               if (store.size() == 0) r.status = dqs_pkg::STS_EMPTY;
               else begin
                  k = int'(index);
                  if (k < 0) k = -k;
                  if (k >= store.size()) r.status = dqs_pkg::STS_RANGE;
                  else begin
                     // negative index counts back from the tail
                     p = (index < 0) ? store.size() - 1 - k : k;
                     r.data = store[p];
                     r.position = POS_W'(p);
                  end
               end
            end
            dqs_pkg::CMD_SEARCH: begin
               if (store.size() == 0) r.status = dqs_pkg::STS_EMPTY;
               else begin
                  r.status = dqs_pkg::STS_NOT_FOUND;
                  for (int i = 0; i < store.size(); i++) begin
                     if (store[i] == value) begin
                        r.status = dqs_pkg::STS_OK;
                        r.data = value;
                        r.position = POS_W'(i);
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         r.count = CNT_W'(store.size());
         owed.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(logic [dqs_pkg::STATUS_WIDTH-1:0] status,
                                   logic [dqs_pkg::VALUE_WIDTH-1:0] data,
                                   logic [POS_W-1:0] position,
                                   logic [CNT_W-1:0] count);
         dq_result_type want;
         if (owed.size() == 0) begin
            $display("%0t: response with no request outstanding: expected none, actual %h/%h",
                     $time, status, data);
            error_count++;
            return;
         end
         want = owed.pop_front();
         compare_field("status", want.status, status);
         compare_field("data", want.data, data);
         compare_field("position", want.position, position);
         compare_field("count", want.count, count);
      endfunction
   endclass

   // Every input starts at a known value; reset is high from time zero.
   logic                                       clock = 1'b0;
   logic                                       reset = 1'b1;
   logic                                       req_valid = 1'b0;
   logic                                       req_stall;
   logic [dqs_pkg::CMD_WIDTH-1:0]              req_cmd = '0;
   logic signed [dqs_pkg::VALUE_WIDTH-1:0]     req_value = '0;
   logic signed [IDX_W-1:0]                    req_index = '0;
   logic                                       rsp_valid;
   logic                                       rsp_stall = 1'b0;
   logic [dqs_pkg::STATUS_WIDTH-1:0]           rsp_status;
   logic signed [dqs_pkg::VALUE_WIDTH-1:0]     rsp_data;
   logic [POS_W-1:0]                           rsp_position;
   logic [CNT_W-1:0]                           rsp_count;

   deque_checker_type sb = new();

   int sent_count = 0;   // requests accepted so far
   bit steady = 1'b0;    // when set, neither side inserts idle cycles
   int hold_left = 0;    // receiver hold-off cycles still to run
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   double_ended_queue_with_search u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .req_index    (req_index),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Biased value: extremes, -1, and small numbers so searches meet duplicates.
   function automatic logic signed [31:0] any_value();
      case ($urandom_range(9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3:    return $urandom_range(7);
         4:       return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [IDX_W-1:0] any_index();
      int v;
      v = $urandom_range(126);
      return IDX_W'(v - 63);
   endfunction

   // Offer one request and hold it until the block takes it. Random idle
   // cycles go in front; valid stays high across back-to-back requests.
   task automatic send_request(dqs_pkg::cmd_type cmd, logic signed [31:0] value,
                               logic signed [IDX_W-1:0] index);
      while (!steady && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      req_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(cmd, value, index);
      sent_count++;
   endtask

   // One random request, shaped by the burst kind and the current fill level.
   task automatic random_request(burst_kind_type kind);
      int fill;
      int r;
      int k;
      dqs_pkg::cmd_type cmd;
      logic signed [31:0] v;
      logic signed [IDX_W-1:0] ix;
      fill = sb.fill_level();
      r = $urandom_range(99);
      cmd = dqs_pkg::cmd_type'($urandom_range(5));
      if (kind == BURST_FILL && r < 90)
         cmd = $urandom_range(1) ? dqs_pkg::CMD_PUSH_BACK : dqs_pkg::CMD_PUSH_FRONT;
      else if (kind == BURST_DRAIN && r < 70)
         cmd = $urandom_range(1) ? dqs_pkg::CMD_POP_BACK : dqs_pkg::CMD_POP_FRONT;
      v = any_value();
      // most searches look for something that is stored
      if (cmd == dqs_pkg::CMD_SEARCH && fill > 0 && $urandom_range(3) != 0)
         v = sb.entry_at($urandom_range(fill - 1));
      ix = any_index();
      if (fill > 0 && $urandom_range(4) != 0) begin
         k = $urandom_range(fill - 1);
         if ($urandom_range(1)) k = -k;
         ix = IDX_W'(k);
      end
      // full queue: hit both ends of the index range
      if (fill == QUEUE_DEPTH && $urandom_range(3) == 0)
         ix = IDX_W'($urandom_range(1) ? 63 : -63);
      send_request(cmd, v, ix);
   endtask

   // Response side: check what is taken, then pick next cycle's stall.
   // Once, well into the run, hold off so the block fills and stalls its
   // request side while the sender keeps offering.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_data, rsp_position, rsp_count);
      if (!hold_done && sent_count >= 520) begin
         hold_left = 300;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 22);
      end
   end

   // Hang detector: any cycle with a handshake on either side restarts it.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      burst_kind_type kind;
      int             burst_len;
      bit             first_burst;
      first_burst = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: pops, read, search and an unused code on an empty queue, then
      // a short queue of five with the value extremes and a duplicate -1 at both ends.
      send_request(dqs_pkg::CMD_POP_BACK, any_value(), any_index());
      send_request(dqs_pkg::CMD_POP_FRONT, any_value(), any_index());
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(0));
      send_request(dqs_pkg::CMD_SEARCH, 0, any_index());
      send_request(dqs_pkg::cmd_type'(CMD_UNUSED_LO), any_value(), any_index());
      send_request(dqs_pkg::CMD_PUSH_BACK, 32'sh7fffffff, any_index());
      send_request(dqs_pkg::CMD_PUSH_FRONT, 32'sh80000000, any_index());
      send_request(dqs_pkg::CMD_PUSH_BACK, 0, any_index());
      send_request(dqs_pkg::CMD_PUSH_BACK, -32'sd1, any_index());
      send_request(dqs_pkg::CMD_PUSH_FRONT, -32'sd1, any_index());
      // unused code on a filled queue leaves it alone
      send_request(dqs_pkg::cmd_type'(CMD_UNUSED_HI), any_value(), any_index());
      // reads: both ends from head and tail, just past the fill level, and the index limits
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(0));
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(4));
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(5));
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(63));
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(-1));
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(-4));
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(-5));
      send_request(dqs_pkg::CMD_READ, any_value(), IDX_W'(-63));
      send_request(dqs_pkg::CMD_READ, any_value(), INDEX_MIN);
      // search: duplicate resolves to the first from the head; then a miss
      send_request(dqs_pkg::CMD_SEARCH, -32'sd1, any_index());
      send_request(dqs_pkg::CMD_SEARCH, 0, any_index());
      send_request(dqs_pkg::CMD_SEARCH, 32'sd12345, any_index());
      send_request(dqs_pkg::CMD_POP_BACK, any_value(), any_index());
      send_request(dqs_pkg::CMD_POP_FRONT, any_value(), any_index());
      send_request(dqs_pkg::CMD_POP_FRONT, any_value(), any_index());

      // Random bursts. The first one fills the queue to full; later ones
      // wander between full and empty. A stretch in the middle runs with
      // no idle cycles on either side.
      while (sent_count < REQUEST_TOTAL) begin
         if (first_burst) begin
            kind = BURST_FILL;
            burst_len = 80;
            first_burst = 1'b0;
         end else begin
            case ($urandom_range(3))
               0:       kind = BURST_FILL;
               1:       kind = BURST_DRAIN;
               default: kind = BURST_MIX;
            endcase
            burst_len = $urandom_range(20, 64);
         end
         repeat (burst_len) begin
            if (sent_count < REQUEST_TOTAL) begin
               steady = (sent_count >= 250 && sent_count < 380);
               random_request(kind);
            end
         end
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      // Wait for every owed response, then give stray ones time to show up.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dqs_pkg.sv
rtl/dqs_ram.sv
rtl/double_ended_queue_with_search.sv
dv/tb.sv
